@@ src/rgt_pkg.sv @@
// Shared types and constants for the radial glow pixel tint pipeline.
package rgt_pkg;

    // Coordinate range of the image.
    localparam int MAX_DIM = 4096;
    localparam int COORD_W = 12;

    // Field widths.
    localparam int CHAN_W   = 8;
    localparam int ASPECT_W = 17;
    localparam int INV_W    = 33;
    localparam int CFG_W    = 33;
    localparam int IDX_W    = 3;

    // Datapath widths.
    localparam int SCALED_W = COORD_W + ASPECT_W;   // scaled offset, Q16
    localparam int SQ_W     = 2 * SCALED_W;         // squared offset, Q32
    localparam int D2_W     = SQ_W + 1;             // squared distance, Q32
    localparam int T_W      = 37;                   // glow strength, Q32, up to 16.0

    // Glow strength saturates at 16.0.
    localparam logic [T_W-1:0] T_LIMIT = T_W'(1) << 36;

    // Register indexes on the configuration port.
    typedef enum logic [IDX_W-1:0] {
        REG_CENTER_X      = 3'd0,
        REG_CENTER_Y      = 3'd1,
        REG_ASPECT_RATIO  = 3'd2,
        REG_SCALE_HORIZ   = 3'd3,
        REG_INV_RANGE     = 3'd4
    } reg_idx_t;

    // One RGB pixel.
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    // Configuration register set.
    typedef struct packed {
        logic [COORD_W-1:0]  center_x;
        logic [COORD_W-1:0]  center_y;
        logic [ASPECT_W-1:0] aspect_ratio;
        logic                scale_horizontal;
        logic [INV_W-1:0]    inv_range;
    } cfg_t;

    // Pipeline control handed to every stage group.
    typedef struct packed {
        logic advance;
        logic valid;
    } pipe_ctl_t;

endpackage

@@ src/radial_glow_pixel_tint.sv @@
// Top level of the radial glow pixel tint: configuration registers and pipeline.
//
//   Channel   Direction  Handshake         Payload
//   s_        in         s_tvalid/tready   col, row, red_in, green_in, blue_in
//   m_        out        m_tvalid/tready   red_out, green_out, blue_out
//   cfg_      in         cfg_wr_en         cfg_index, cfg_wr_data
//
// Eight register stages; one item enters per cycle while the pipeline advances.
// The rate is set by the single shared pipeline enable: the whole pipeline
// holds while the output register is full and not taken.
// Reset clears all valid bits and loads the configuration reset values.
module radial_glow_pixel_tint (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Input items.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [47:0]                 s_tdata,   // col[11:0], row[23:12], red_in[31:24],
                                                   // green_in[39:32], blue_in[47:40]
    // Result items.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,   // red_out[7:0], green_out[15:8],
                                                   // blue_out[23:16]
    // Configuration writes.
    input  logic                        cfg_wr_en,
    input  logic [rgt_pkg::IDX_W-1:0]   cfg_index,
    input  logic [rgt_pkg::CFG_W-1:0]   cfg_wr_data
);
    import rgt_pkg::*;

    cfg_t                cfg_reg, cfg_next;
    pipe_ctl_t           ctl, ctl_g, ctl_t;
    logic                advance;
    logic [COORD_W-1:0]  col, row;
    pixel_t              pix_in, pix_d, pix_g, pix_o;
    logic [D2_W-1:0]     d2;
    logic [T_W-1:0]      t;
    logic                valid_d, valid_g;

    // Configuration register writes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_index))
                REG_CENTER_X:     cfg_next.center_x         = cfg_wr_data[COORD_W-1:0];
                REG_CENTER_Y:     cfg_next.center_y         = cfg_wr_data[COORD_W-1:0];
                REG_ASPECT_RATIO: cfg_next.aspect_ratio     = cfg_wr_data[ASPECT_W-1:0];
                REG_SCALE_HORIZ:  cfg_next.scale_horizontal = cfg_wr_data[0];
                REG_INV_RANGE:    cfg_next.inv_range        = cfg_wr_data[INV_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.center_x         <= '0;
            cfg_reg.center_y         <= '0;
            cfg_reg.aspect_ratio     <= ASPECT_W'(65536);
            cfg_reg.scale_horizontal <= 1'b0;
            cfg_reg.inv_range        <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // The pipeline moves whenever the output register is free or being taken.
    assign advance       = !m_tvalid || m_tready;
    assign s_tready      = advance;
    assign ctl.advance   = advance;
    assign ctl.valid     = s_tvalid;
    assign ctl_g.advance = advance;
    assign ctl_g.valid   = valid_d;
    assign ctl_t.advance = advance;
    assign ctl_t.valid   = valid_g;

    // Unpack the input item.
    assign col          = s_tdata[11:0];
    assign row          = s_tdata[23:12];
    assign pix_in.red   = s_tdata[31:24];
    assign pix_in.green = s_tdata[39:32];
    assign pix_in.blue  = s_tdata[47:40];

    rgt_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_in    (ctl),
        .cfg       (cfg_reg),
        .col       (col),
        .row       (row),
        .pix_in    (pix_in),
        .valid_out (valid_d),
        .d2_out    (d2),
        .pix_out   (pix_d)
    );

    rgt_glow u_glow (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_in    (ctl_g),
        .inv_range (cfg_reg.inv_range),
        .d2_in     (d2),
        .pix_in    (pix_d),
        .valid_out (valid_g),
        .t_out     (t),
        .pix_out   (pix_g)
    );

    rgt_tint u_tint (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_in    (ctl_t),
        .t_in      (t),
        .pix_in    (pix_g),
        .valid_out (m_tvalid),
        .pix_out   (pix_o)
    );

    // Pack the result item.
    assign m_tdata = {pix_o.blue, pix_o.green, pix_o.red};

endmodule

@@ src/rgt_dist.sv @@
// Stages one to three: center offsets, aspect scaling, squares and squared distance.
module rgt_dist (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rgt_pkg::pipe_ctl_t                ctl_in,
    input  rgt_pkg::cfg_t                     cfg,
    input  logic [rgt_pkg::COORD_W-1:0]       col,
    input  logic [rgt_pkg::COORD_W-1:0]       row,
    input  rgt_pkg::pixel_t                   pix_in,
    output logic                              valid_out,
    output logic [rgt_pkg::D2_W-1:0]          d2_out,
    output rgt_pkg::pixel_t                   pix_out
);
    import rgt_pkg::*;

    // Saturate a coordinate to the image size.
    function automatic logic [COORD_W-1:0] clip_coord(input logic [COORD_W-1:0] v);
        logic [COORD_W-1:0] lim;
        lim = COORD_W'(MAX_DIM - 1);
        clip_coord = (v > lim) ? lim : v;
    endfunction

    logic [COORD_W-1:0]  col_c, row_c, adx, ady;
    logic [SCALED_W-1:0] adx_scaled, ady_scaled, adx_shift, ady_shift;
    logic [SCALED_W-1:0] sx_next, sy_next, sx_reg, sy_reg;
    logic [SQ_W-1:0]     sqx_next, sqy_next, sqx_reg, sqy_reg;
    logic [D2_W-1:0]     d2_next, d2_reg;
    pixel_t              pix1_reg, pix2_reg, pix3_reg;
    logic                v1_reg, v2_reg, v3_reg;

    // Stage one: absolute offsets, one of them scaled by the aspect ratio.
    always_comb begin
        col_c      = clip_coord(col);
        row_c      = clip_coord(row);
        adx        = (cfg.center_x >= col_c) ? cfg.center_x - col_c : col_c - cfg.center_x;
        ady        = (cfg.center_y >= row_c) ? cfg.center_y - row_c : row_c - cfg.center_y;
        adx_scaled = SCALED_W'(adx) * SCALED_W'(cfg.aspect_ratio);
        ady_scaled = SCALED_W'(ady) * SCALED_W'(cfg.aspect_ratio);
        adx_shift  = SCALED_W'({adx, 16'b0});
        ady_shift  = SCALED_W'({ady, 16'b0});
        if (cfg.scale_horizontal) begin
            sx_next = adx_scaled;
            sy_next = ady_shift;
        end else begin
            sx_next = adx_shift;
            sy_next = ady_scaled;
        end
    end

    // Stage two: squares of both offsets.
    always_comb begin
        sqx_next = SQ_W'(sx_reg) * SQ_W'(sx_reg);
        sqy_next = SQ_W'(sy_reg) * SQ_W'(sy_reg);
    end

    // Stage three: squared distance.
    assign d2_next = D2_W'(sqx_reg) + D2_W'(sqy_reg);

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (ctl_in.advance) begin
            v1_reg <= ctl_in.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (ctl_in.advance) begin
            sx_reg   <= sx_next;
            sy_reg   <= sy_next;
            pix1_reg <= pix_in;
            sqx_reg  <= sqx_next;
            sqy_reg  <= sqy_next;
            pix2_reg <= pix1_reg;
            d2_reg   <= d2_next;
            pix3_reg <= pix2_reg;
        end
    end

    assign valid_out = v3_reg;
    assign d2_out    = d2_reg;
    assign pix_out   = pix3_reg;

endmodule

@@ src/rgt_glow.sv @@
// Stages four to six: glow strength from squared distance and the reciprocal range.
module rgt_glow (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rgt_pkg::pipe_ctl_t        ctl_in,
    input  logic [rgt_pkg::INV_W-1:0] inv_range,
    input  logic [rgt_pkg::D2_W-1:0]  d2_in,
    input  rgt_pkg::pixel_t           pix_in,
    output logic                      valid_out,
    output logic [rgt_pkg::T_W-1:0]   t_out,
    output rgt_pkg::pixel_t           pix_out
);
    import rgt_pkg::*;

    localparam int DL_W  = 30;
    localparam int DH_W  = D2_W - DL_W;
    localparam int IL_W  = 16;
    localparam int IH_W  = INV_W - IL_W;
    localparam int P0_W  = DL_W + IL_W;
    localparam int P1_W  = DL_W + IH_W;
    localparam int P2_W  = DH_W + IL_W;
    localparam int P3_W  = DH_W + IH_W;
    localparam int A_W   = P1_W + IL_W + 1;
    localparam int B_W   = P3_W + IL_W + 1;
    localparam int PR_W  = B_W + DL_W;
    localparam int TF_W  = PR_W - 32;

    logic [DL_W-1:0] dl;
    logic [DH_W-1:0] dh;
    logic [IL_W-1:0] il;
    logic [IH_W-1:0] ih;
    logic [P0_W-1:0] p0_reg;
    logic [P1_W-1:0] p1_reg;
    logic [P2_W-1:0] p2_reg;
    logic [P3_W-1:0] p3_reg;
    logic [A_W-1:0]  a_next, a_reg;
    logic [B_W-1:0]  b_next, b_reg;
    logic [PR_W-1:0] prod;
    logic [TF_W-1:0] t_full;
    logic [T_W-1:0]  t_next, t_reg;
    pixel_t          pix4_reg, pix5_reg, pix6_reg;
    logic            v4_reg, v5_reg, v6_reg;

    // Stage four: four partial products of the wide multiply.
    assign dl = d2_in[DL_W-1:0];
    assign dh = d2_in[D2_W-1:DL_W];
    assign il = inv_range[IL_W-1:0];
    assign ih = inv_range[INV_W-1:IL_W];

    // Stage five: combine products that share a weight of the distance half.
    assign a_next = A_W'(p0_reg) + A_W'({p1_reg, {IL_W{1'b0}}});
    assign b_next = B_W'(p2_reg) + B_W'({p3_reg, {IL_W{1'b0}}});

    // Stage six: full product, keep Q32 and saturate at 16.0.
    always_comb begin
        prod   = PR_W'(a_reg) + {b_reg, {DL_W{1'b0}}};
        t_full = prod[PR_W-1:32];
        t_next = (t_full > TF_W'(T_LIMIT)) ? T_LIMIT : t_full[T_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (ctl_in.advance) begin
            v4_reg <= ctl_in.valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_in.advance) begin
            p0_reg   <= P0_W'(dl) * P0_W'(il);
            p1_reg   <= P1_W'(dl) * P1_W'(ih);
            p2_reg   <= P2_W'(dh) * P2_W'(il);
            p3_reg   <= P3_W'(dh) * P3_W'(ih);
            pix4_reg <= pix_in;
            a_reg    <= a_next;
            b_reg    <= b_next;
            pix5_reg <= pix4_reg;
            t_reg    <= t_next;
            pix6_reg <= pix5_reg;
        end
    end

    assign valid_out = v6_reg;
    assign t_out     = t_reg;
    assign pix_out   = pix6_reg;

endmodule

@@ src/rgt_tint.sv @@
// Stages seven and eight: brighten, tint green and saturate each channel.
module rgt_tint (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  rgt_pkg::pipe_ctl_t      ctl_in,
    input  logic [rgt_pkg::T_W-1:0] t_in,
    input  rgt_pkg::pixel_t         pix_in,
    output logic                    valid_out,
    output rgt_pkg::pixel_t         pix_out
);
    import rgt_pkg::*;

    localparam int ADD_W = 12;              // floor(255t) is at most 4080
    localparam int SUM_W = 13;
    localparam int NEG_W = T_W + 7;         // 120t in Q32
    localparam int POS_W = SUM_W + 32;

    // Clamp a channel sum to eight bits.
    function automatic logic [CHAN_W-1:0] sat8(input logic [SUM_W-1:0] v);
        sat8 = (v > SUM_W'(255)) ? 8'hFF : v[CHAN_W-1:0];
    endfunction

    logic [T_W+7:0]     t255;
    logic [ADD_W-1:0]   add;
    logic [NEG_W-1:0]   neg_next, neg_reg;
    logic [SUM_W-1:0]   r_sum_next, b_sum_next, g_pos_next;
    logic [SUM_W-1:0]   r_sum_reg, b_sum_reg, g_pos_reg;
    logic [POS_W-1:0]   pos, diff;
    logic [SUM_W-1:0]   gv;
    pixel_t             out_next, out_reg;
    logic               v7_reg, v8_reg;

    // Stage seven: 255t and 120t by shifts, channel sums.
    always_comb begin
        t255       = {t_in, 8'b0} - (T_W+8)'(t_in);
        add        = t255[32 +: ADD_W];
        neg_next   = {t_in, 7'b0} - NEG_W'({t_in, 3'b0});
        r_sum_next = SUM_W'(pix_in.red) + SUM_W'(add);
        b_sum_next = SUM_W'(pix_in.blue) + SUM_W'(add);
        g_pos_next = SUM_W'(pix_in.green) + SUM_W'(add) + SUM_W'(120);
    end

    // Stage eight: subtract the green pull-back and saturate.
    always_comb begin
        pos  = {g_pos_reg, 32'b0};
        diff = pos - POS_W'(neg_reg);
        gv   = (pos >= POS_W'(neg_reg)) ? diff[POS_W-1:32] : '0;
        out_next.red   = sat8(r_sum_reg);
        out_next.green = sat8(gv);
        out_next.blue  = sat8(b_sum_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else if (ctl_in.advance) begin
            v7_reg <= ctl_in.valid;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_in.advance) begin
            neg_reg   <= neg_next;
            r_sum_reg <= r_sum_next;
            b_sum_reg <= b_sum_next;
            g_pos_reg <= g_pos_next;
            out_reg   <= out_next;
        end
    end

    assign valid_out = v8_reg;
    assign pix_out   = out_reg;

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for radial_glow_pixel_tint with its own tint predictor.
module tb;
    import rgt_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_MAX   = 10;
    localparam int CHUNK_ITEMS  = 50;
    localparam int END_WAIT_MAX = 100000;
    localparam int RUN_LIMIT    = 600000;
    localparam int GLOW_GAIN    = 255;
    localparam int GREEN_TINT   = 120;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [47:0]        s_tdata;   // col[11:0], row[23:12], red_in[31:24],
                                   // green_in[39:32], blue_in[47:40]
    logic               m_tvalid;
    logic               m_tready;
    logic [23:0]        m_tdata;   // red_out[7:0], green_out[15:8], blue_out[23:16]
    logic               cfg_wr_en;
    logic [IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]   cfg_wr_data;

    // Predictor copy of the configuration registers.
    logic [COORD_W-1:0]  cur_col0;
    logic [COORD_W-1:0]  cur_row0;
    logic [ASPECT_W-1:0] cur_aspect;
    logic                cur_scale_col;
    logic [INV_W-1:0]    cur_inv;

    // Tinted pixels still owed by the block, oldest first.
    pixel_t pending_tints[$];

    int   fail_count = 0;
    int   n_reported = 0;
    int   n_sent     = 0;
    int   n_checked  = 0;
    int   n_setups   = 0;
    int   send_idle_pct = 0;
    int   stall_pct;
    int   hold_left  = 0;
    logic hold_start;

    radial_glow_pixel_tint u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        aclk = 1'b0;
        #CLK_HALF;
        aclk = 1'b1;
        #CLK_HALF;
    end

    function automatic logic [CHAN_W-1:0] sat_chan(input logic [63:0] v);
        return (v > 64'd255) ? 8'd255 : v[CHAN_W-1:0];
    endfunction

    // Expected tinted pixel for one input item under the current settings.
    function automatic pixel_t tint_pixel(input logic [COORD_W-1:0] col,
                                          input logic [COORD_W-1:0] row,
                                          input pixel_t px);
        logic [COORD_W-1:0]  off_x;
        logic [COORD_W-1:0]  off_y;
        logic [SCALED_W-1:0] sc_x;
        logic [SCALED_W-1:0] sc_y;
        logic [D2_W-1:0]     dist_sq;
        logic [127:0]        glow_full;
        logic [63:0]         glow;
        logic [63:0]         lift;
        logic [63:0]         green_sum;
        logic [63:0]         pos;
        logic [63:0]         neg;
        pixel_t              res;
        off_x = (cur_col0 >= col) ? cur_col0 - col : col - cur_col0;
        off_y = (cur_row0 >= row) ? cur_row0 - row : row - cur_row0;
        // Only the axis picked by the scale flag gets the aspect ratio; the other is a plain Q16 shift.
        if (cur_scale_col) begin
            sc_x = SCALED_W'(off_x) * SCALED_W'(cur_aspect);
            sc_y = SCALED_W'({off_y, 16'd0});
        end else begin
            sc_x = SCALED_W'({off_x, 16'd0});
            sc_y = SCALED_W'(off_y) * SCALED_W'(cur_aspect);
        end
        dist_sq   = D2_W'(sc_x) * D2_W'(sc_x) + D2_W'(sc_y) * D2_W'(sc_y);
        glow_full = 128'(dist_sq) * 128'(cur_inv);
        // Glow strength in Q32, clamped at 16.0.
        if ((glow_full >> 32) > 128'(T_LIMIT))
            glow = 64'(T_LIMIT);
        else
            glow = glow_full[95:32];
        lift      = (64'(GLOW_GAIN) * glow) >> 32;
        green_sum = 64'(px.green) + lift;
        pos       = (green_sum + 64'(GREEN_TINT)) << 32;
        neg       = 64'(GREEN_TINT) * glow;
        res.red   = sat_chan(64'(px.red) + lift);
        res.green = sat_chan((pos >= neg) ? (pos - neg) >> 32 : 64'd0);
        res.blue  = sat_chan(64'(px.blue) + lift);
        return res;
    endfunction

    // Result side: compare every accepted result with the oldest expectation.
    always @(posedge aclk) begin : result_check
        pixel_t got;
        pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]};
            n_checked++;
            if (pending_tints.size() == 0) begin
                fail_count++;
                if (n_reported < REPORT_MAX)
                    $display("unexpected result %h with no item pending", m_tdata);
                n_reported++;
            end else begin
                want = pending_tints.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue) begin
                    fail_count++;
                    if (n_reported < REPORT_MAX)
                        $display("result %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                 n_checked, want.red, want.green, want.blue,
                                 got.red, got.green, got.blue);
                    n_reported++;
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (hold_start)
            hold_left = HOLD_CYCLES;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one item, idling first at the current rate, and wait until it is taken.
    task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                              input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r, row, col};
        do @(posedge aclk); while (!s_tready);
        pending_tints.push_back(tint_pixel(col, row, {r, g, b}));
        n_sent++;
    endtask

    // Sender stops and waits for every owed result, then lets the pipeline run empty.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_tints.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic put_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
    endtask

    // Write all five registers; only called while the block is idle.
    task automatic set_config(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                              input logic [ASPECT_W-1:0] ar, input logic sh,
                              input logic [INV_W-1:0] inv);
        put_reg(REG_CENTER_X, CFG_W'(cx));
        put_reg(REG_CENTER_Y, CFG_W'(cy));
        put_reg(REG_ASPECT_RATIO, CFG_W'(ar));
        put_reg(REG_SCALE_HORIZ, CFG_W'(sh));
        put_reg(REG_INV_RANGE, CFG_W'(inv));
        cfg_wr_en     <= 1'b0;
        cur_col0      = cx;
        cur_row0      = cy;
        cur_aspect    = ar;
        cur_scale_col = sh;
        cur_inv       = inv;
        n_setups++;
    endtask

    task automatic pick_random_setup();
        logic [ASPECT_W-1:0] ar;
        logic [INV_W-1:0]    inv;
        int                  sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            ar = 17'h10000;
        else if (sel < 80)
            ar = ASPECT_W'($urandom_range(0, 65536));
        else
            ar = ASPECT_W'($urandom_range(0, 131071));
        // Mostly falloff ranges that give a visible gradient, some saturating ones.
        sel = $urandom_range(0, 99);
        if (sel < 10)
            inv = '0;
        else if (sel < 15)
            inv = '1;
        else if (sel < 60)
            inv = INV_W'($urandom_range(1, 8191));
        else if (sel < 80)
            inv = INV_W'($urandom_range(8192, 1 << 20));
        else
            inv = {1'($urandom_range(0, 1)), $urandom};
        set_config(COORD_W'($urandom_range(0, 4095)), COORD_W'($urandom_range(0, 4095)), ar,
                   1'($urandom_range(0, 1)), inv);
    endtask

    // Random pixel: half of them near the center where the glow varies most.
    task automatic send_random_pixel();
        int c;
        int r;
        if ($urandom_range(0, 1)) begin
            c = int'(cur_col0) + int'($urandom_range(0, 1200)) - 600;
            r = int'(cur_row0) + int'($urandom_range(0, 1200)) - 600;
            if (c < 0) c = 0;
            if (c > MAX_DIM - 1) c = MAX_DIM - 1;
            if (r < 0) r = 0;
            if (r > MAX_DIM - 1) r = MAX_DIM - 1;
        end else begin
            c = $urandom_range(0, MAX_DIM - 1);
            r = $urandom_range(0, MAX_DIM - 1);
        end
        send_pixel(COORD_W'(c), COORD_W'(r), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Reset settings: zero falloff reciprocal, so only the green tint applies.
    task automatic test_reset_defaults();
        send_pixel(12'd0, 12'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255);
        send_pixel(12'd2047, 12'd1024, 8'd10, 8'd200, 8'd135);
    endtask

    // Hand-picked settings and pixels: center, corners, saturation, aspect extremes.
    task automatic test_directed_cases();
        // Landscape image with a realistic falloff.
        drain_results();
        set_config(12'd960, 12'd540, 17'd36864, 1'b1, 33'd24548);
        send_pixel(12'd960, 12'd540, 8'd50, 8'd60, 8'd70);
        send_pixel(12'd0, 12'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(12'd1919, 12'd1079, 8'd128, 8'd128, 8'd128);
        send_pixel(12'd1200, 12'd700, 8'd255, 8'd0, 8'd255);
        send_pixel(12'd700, 12'd300, 8'd1, 8'd254, 8'd1);
        // Aspect ratio above one on the vertical axis.
        drain_results();
        set_config(12'd100, 12'd4095, 17'd131071, 1'b0, 33'd1);
        send_pixel(12'd0, 12'd0, 8'd33, 8'd66, 8'd99);
        send_pixel(12'd4095, 12'd4095, 8'd200, 8'd100, 8'd0);
        send_pixel(12'd100, 12'd4000, 8'd0, 8'd255, 8'd0);
        // Zero aspect ratio wipes out the horizontal offset.
        drain_results();
        set_config(12'd4095, 12'd0, 17'd0, 1'b1, 33'd4095);
        send_pixel(12'd0, 12'd0, 8'd12, 8'd34, 8'd56);
        send_pixel(12'd0, 12'd4095, 8'd0, 8'd0, 8'd0);
        send_pixel(12'd4095, 12'd2000, 8'd255, 8'd128, 8'd7);
        // Largest reciprocal: the glow clamps at its upper limit.
        drain_results();
        set_config(12'd0, 12'd0, 17'h10000, 1'b0, '1);
        send_pixel(12'd4095, 12'd4095, 8'd0, 8'd0, 8'd0);
        send_pixel(12'd1, 12'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(12'd0, 12'd0, 8'd77, 8'd88, 8'd99);
        // Glow strengths of 0, 0.25 and 1.0 next to the center.
        drain_results();
        set_config(12'd2048, 12'd2048, 17'h10000, 1'b1, 33'h040000000);
        send_pixel(12'd2049, 12'd2048, 8'd0, 8'd0, 8'd0);
        send_pixel(12'd2050, 12'd2048, 8'd0, 8'd0, 8'd0);
        send_pixel(12'd2048, 12'd2049, 8'd100, 8'd50, 8'd0);
        send_pixel(12'd2048, 12'd2048, 8'd255, 8'd255, 8'd255);
    endtask

    // Random items in chunks, each chunk under fresh settings.
    task automatic test_random_phase(input int n_chunks, input int send_pct,
                                     input int recv_pct);
        drain_results();
        send_idle_pct = send_pct;
        stall_pct    <= recv_pct;
        repeat (n_chunks) begin
            drain_results();
            pick_random_setup();
            repeat (CHUNK_ITEMS) send_random_pixel();
        end
    endtask

    // Long output hold-off while the sender keeps offering, then a drain and a run with random stalls.
    task automatic test_backpressure();
        drain_results();
        pick_random_setup();
        send_idle_pct = 0;
        stall_pct    <= 0;
        hold_start   <= 1'b1;
        @(posedge aclk);
        hold_start   <= 1'b0;
        repeat (100) send_random_pixel();
        drain_results();
        stall_pct    <= 50;
        repeat (100) send_random_pixel();
    endtask

    initial begin
        int end_wait;
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= REG_CENTER_X;
        cfg_wr_data <= '0;
        hold_start  <= 1'b0;
        stall_pct   <= 0;
        cur_col0      = '0;
        cur_row0      = '0;
        cur_aspect    = 17'h10000;
        cur_scale_col = 1'b0;
        cur_inv       = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_directed_cases();
        test_random_phase(5, 0, 0);
        test_random_phase(5, 87, 0);
        test_random_phase(5, 0, 87);
        test_random_phase(5, 18, 18);
        test_backpressure();

        // Wait for the last results, bounded, then let the pipeline run empty.
        s_tvalid <= 1'b0;
        end_wait = 0;
        while (pending_tints.size() != 0 && end_wait < END_WAIT_MAX) begin
            @(posedge aclk);
            end_wait++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_tints.size() != 0) begin
            $display("%0d expected results never arrived", pending_tints.size());
            fail_count += pending_tints.size();
        end

        $display("Sent %0d pixels under %0d register settings; %0d results checked, %0d bad.",
                 n_sent, n_setups, n_checked, fail_count);
        $display("Covered reset values, glow clamp, aspect extremes, idle mixes, %0d-cycle hold.",
                 HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #(2 * CLK_HALF * RUN_LIMIT);
        $display("simulation failed");
        $finish;
    end

endmodule
